// ----- sv/tsec_pkg.sv -----
// ----------------------------------------------------------------------------
// Touch slot event classifier package
// Shared types and constants: event kinds, register indexes, bus words and
// the pending-move pick result.
// ----------------------------------------------------------------------------
package tsec_pkg;

  localparam int unsigned MaxResults  = 3;
  localparam int unsigned CntW        = 2;
  localparam int unsigned SlotIdxMaxW = 4;
  localparam int unsigned CoordW      = 15;
  localparam int unsigned ThrW        = 16;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned InDataW     = 72;
  localparam int unsigned OutDataW    = 40;

  localparam logic [ThrW-1:0] MoveThrReset = 16'd5;
  localparam logic [ThrW-1:0] DcWinReset   = 16'd300;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOVE    = 2'd2,
    EV_DOUBLE  = 2'd3
  } event_kind_e;

  typedef enum logic {
    REG_MOVE_THRESHOLD    = 1'b0,
    REG_DOUBLE_CLICK_WIN  = 1'b1
  } cfg_reg_e;

  // Input word, listed from the top bit down.
  typedef struct packed {
    logic [1:0]       pad;
    logic [TimeW-1:0] time_ms;
    logic             contact_down;
    logic [15:0]      pos_y;
    logic [15:0]      pos_x;
    logic [3:0]       slot;
    logic             sample_valid;
  } in_word_t;

  // Output word, listed from the top bit down.
  typedef struct packed {
    logic [5:0]        pad;
    logic [CoordW-1:0] event_y;
    logic [CoordW-1:0] event_x;
    logic [3:0]        event_slot;
  } out_word_t;

  // Lowest pending slot and whether another one is pending behind it.
  typedef struct packed {
    logic                   found;
    logic                   more;
    logic [SlotIdxMaxW-1:0] idx;
  } pick_t;

endpackage

// ----- sv/touch_slot_event_classifier.sv -----
// ----------------------------------------------------------------------------
// Touch slot event classifier
// An input word passes through the input register, then the result register.
// A sample needing no move flush leaves the input register once the output is
// free, so words stream at one per cycle while the output is not stalled; a
// batch-end sample stays while its pending moves flush (at most three events).
// Reset clears the slot flags and restores the register defaults.
// ----------------------------------------------------------------------------
module touch_slot_event_classifier #(
  parameter int unsigned SLOT_COUNT = 2
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample_valid[0], slot[4:1], pos_x[20:5], pos_y[36:21], contact_down[37],
  // time_ms[69:38], zero[71:70]
  input  logic [tsec_pkg::InDataW-1:0]  s_axis_tdata,
  input  logic                          s_axis_tlast,   // batch_end
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // event_slot[3:0], event_x[18:4], event_y[33:19], zero[39:34]
  output logic [tsec_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,   // event_kind[1:0]
  output logic                          m_axis_tlast,   // last_result
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [15:0]                   cfg_data_i
);
  import tsec_pkg::*;

  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  // Configuration
  logic [ThrW-1:0] thr_q, win_q;

  // Input register
  logic     in_vld_q;
  in_word_t in_q;
  logic     in_last_q;

  // Slot state
  logic [SLOT_COUNT-1:0] active_q, seen_q, pend_q;
  logic [CoordW-1:0]     lx_q [SLOT_COUNT];
  logic [CoordW-1:0]     ly_q [SLOT_COUNT];
  logic [TimeW-1:0]      lt_q [SLOT_COUNT];

  // Sequencing
  logic            flush_q;
  logic [CntW-1:0] cnt_q;

  // Result register
  logic              out_vld_q;
  out_word_t         out_q;
  event_kind_e       kind_q;
  logic              last_q;

  pick_t             pick;
  logic              out_free, go, consume;
  logic [SW-1:0]     slot_idx, pick_idx, rd_idx;
  logic              rd_active, rd_seen;
  logic [CoordW-1:0] rd_x, rd_y, px, py, dx, dy;
  logic [TimeW-1:0]  rd_time, tdiff;
  logic              sample_ok, moved, dbl;
  logic              do_release, do_move, do_press, evt, want_flush;
  logic              emit_f, last_f, emit;
  event_kind_e       kind_d;
  logic              last_d;
  logic [CoordW-1:0] ox_d, oy_d;
  logic [3:0]        oslot_d;

  tsec_pick #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_pick (
    .pend_i(pend_q),
    .pick_o(pick)
  );

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= MoveThrReset;
      win_q <= DcWinReset;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MOVE_THRESHOLD:   thr_q <= cfg_data_i;
        REG_DOUBLE_CLICK_WIN: win_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free = !out_vld_q || m_axis_tready;
  assign go       = in_vld_q && out_free;

  assign slot_idx = in_q.slot[SW-1:0];
  assign pick_idx = pick.idx[SW-1:0];
  // One read port: the sample's slot, or the move being flushed.
  assign rd_idx   = flush_q ? pick_idx : slot_idx;

  assign rd_active = active_q[rd_idx];
  assign rd_seen   = seen_q[rd_idx];
  assign rd_x      = lx_q[rd_idx];
  assign rd_y      = ly_q[rd_idx];
  assign rd_time   = lt_q[rd_idx];

  assign px = in_q.pos_x[CoordW-1:0];
  assign py = in_q.pos_y[CoordW-1:0];
  assign dx = (rd_x >= px) ? rd_x - px : px - rd_x;
  assign dy = (rd_y >= py) ? rd_y - py : py - rd_y;

  assign sample_ok = in_q.sample_valid && ({1'b0, in_q.slot} < 5'(SLOT_COUNT)) &&
                     !in_q.pos_x[15] && !in_q.pos_y[15];
  assign moved     = ({1'b0, dx} >= thr_q) || ({1'b0, dy} >= thr_q);

  // A negative wrapped difference also counts as inside the window.
  assign tdiff = in_q.time_ms - rd_time;
  assign dbl   = rd_seen && (tdiff[TimeW-1] || (tdiff < {16'd0, win_q}));

  assign do_release = sample_ok && rd_active && !in_q.contact_down;
  assign do_move    = sample_ok && rd_active && in_q.contact_down && moved;
  assign do_press   = sample_ok && !rd_active && in_q.contact_down;
  assign evt        = do_release || do_press;
  assign want_flush = in_last_q && ((|pend_q) || do_move);

  assign emit_f = pick.found;
  assign last_f = !pick.found || !pick.more || (cnt_q == CntW'(MaxResults - 1));

  assign emit    = go && (flush_q ? emit_f : evt);
  assign consume = go && (flush_q ? last_f : !want_flush);

  assign s_axis_tready = !in_vld_q || consume;

  always_comb begin
    if (flush_q) begin
      kind_d  = EV_MOVE;
      last_d  = last_f;
      ox_d    = rd_x;
      oy_d    = rd_y;
      oslot_d = pick.idx;
    end else begin
      if (do_release) begin
        kind_d = EV_RELEASE;
      end else if (dbl) begin
        kind_d = EV_DOUBLE;
      end else begin
        kind_d = EV_PRESS;
      end
      last_d  = !want_flush;
      ox_d    = px;
      oy_d    = py;
      oslot_d = in_q.slot;
    end
  end

  // Input register and sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      flush_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (go) begin
        if (flush_q) begin
          cnt_q   <= cnt_q + CntW'(1);
          flush_q <= !last_f;
        end else begin
          cnt_q   <= evt ? CntW'(1) : '0;
          flush_q <= want_flush;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q      <= in_word_t'(s_axis_tdata);
      in_last_q <= s_axis_tlast;
    end
  end

  // Slot flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      seen_q   <= '0;
      pend_q   <= '0;
    end else if (go) begin
      if (flush_q) begin
        if (emit_f) begin
          pend_q[pick_idx] <= 1'b0;
        end
      end else begin
        if (do_release) begin
          active_q[slot_idx] <= 1'b0;
        end
        if (do_move) begin
          pend_q[slot_idx] <= 1'b1;
        end
        if (do_press) begin
          active_q[slot_idx] <= !dbl;
          seen_q[slot_idx]   <= 1'b1;
        end
      end
    end
  end

  // Slot points and press times
  always_ff @(posedge clk_i) begin
    if (go && !flush_q) begin
      if (do_release || do_move || do_press) begin
        lx_q[slot_idx] <= px;
        ly_q[slot_idx] <= py;
      end
      if (do_press) begin
        lt_q[slot_idx] <= in_q.time_ms;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q.pad        <= '0;
      out_q.event_y    <= oy_d;
      out_q.event_x    <= ox_d;
      out_q.event_slot <= oslot_d;
      kind_q           <= kind_d;
      last_q           <= last_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutDataW'(out_q);
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

endmodule

// ----- sv/tsec_pick.sv -----
// ----------------------------------------------------------------------------
// Pending move picker
// Finds the lowest slot with a pending move and flags further pending slots.
// ----------------------------------------------------------------------------
module tsec_pick #(
  parameter int unsigned SLOT_COUNT = 2
) (
  input  logic [SLOT_COUNT-1:0] pend_i,
  output tsec_pkg::pick_t       pick_o
);
  import tsec_pkg::*;

  logic [SLOT_COUNT-1:0]  rest;
  logic [SlotIdxMaxW-1:0] idx;

  // Clearing the lowest set bit leaves whatever else is pending.
  assign rest = pend_i & (pend_i - SLOT_COUNT'(1));

  always_comb begin
    idx = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (pend_i[i]) begin
        idx = SlotIdxMaxW'(i);
      end
    end
  end

  assign pick_o.found = |pend_i;
  assign pick_o.more  = |rest;
  assign pick_o.idx   = idx;

endmodule
